@@ rtl/assert_macros.svh @@
// Assertion macros shared by the agent RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define QLTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under a synchronous active-low reset.
`define QLTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qlta_pkg.sv @@
// Types, codes, fixed widths and table dimensions of the Q-learning table agent.
// Depends on nothing; used by the interfaces and the top level.
package qlta_pkg;

    // The row count MAX_POSITIONS*HISTORY_SLOTS must be a power of two, because rows are
    // folded into the table by keeping the low index bits.
    localparam int MAX_POSITIONS = 64;
    localparam int HISTORY_SLOTS = 16;
    localparam int ACTIONS       = 9;

    localparam int QW     = 27;
    localparam int POS_W  = 7;
    localparam int IT_W   = 5;
    localparam int RND_W  = 16;
    localparam int CFG_W  = 17;
    localparam int ES_W   = 7;
    localparam int ACT_W  = 4;
    localparam int CIDX_W = 2;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q Q_INIT = 27'sd131072;
    localparam logic [CFG_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        CMD_CHOOSE = 2'd0,
        CMD_RECORD = 2'd1,
        CMD_LEARN  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SAT       = 2'd1,
        ST_NO_ACTION = 2'd2
    } t_status;

    typedef enum logic [CIDX_W-1:0] {
        CFG_LEARN_RATE = 2'd0,
        CFG_DISCOUNT   = 2'd1,
        CFG_EXPLORE    = 2'd2,
        CFG_ENV_STATES = 2'd3
    } t_cfg_idx;

    function automatic logic [CFG_W-1:0] clamp_one(input logic [CFG_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

@@ rtl/qlta_cmd_if.sv @@
// Command channel of the agent: valid, ready and one command item.
// Depends on qlta_pkg.
interface qlta_cmd_if import qlta_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_cmd                    command;
    logic [POS_W-1:0]        position;
    logic [IT_W-1:0]         iteration;
    logic signed [QW-1:0]    reward;
    logic [RND_W-1:0]        rand_explore;
    logic [RND_W-1:0]        rand_pick;

    modport source(output valid, command, position, iteration, reward, rand_explore,
                   rand_pick, input ready);
    modport sink(input valid, command, position, iteration, reward, rand_explore,
                 rand_pick, output ready);
endinterface

@@ rtl/qlta_res_if.sv @@
// Result channel of the agent: valid, ready and one result item.
// Depends on qlta_pkg.
interface qlta_res_if import qlta_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [QW-1:0]    max_value;
    logic                    explored;
    t_status                 status;

    modport source(output valid, action, max_value, explored, status, input ready);
    modport sink(input valid, action, max_value, explored, status, output ready);
endinterface

@@ rtl/qlta_rem.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on nothing.
module qlta_rem #(
    parameter int DW = 16,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [VW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_sh;
    logic [VW-1:0] r_div;
    logic [VW-1:0] r_rem;
    logic [VW:0]   w_trial;
    logic          w_fits;

    assign w_trial = {r_rem, r_sh[DW-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
            r_sh   <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem <= w_fits ? VW'(w_trial - {1'b0, r_div}) : w_trial[VW-1:0];
                r_sh  <= r_sh << 1;
                r_cnt <= r_cnt - CW'(1);
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_rem  = r_rem;
endmodule

@@ rtl/qlta_mem.sv @@
// Row-wide table memory: one write port and one read port, read data registered.
// Depends on nothing.
module qlta_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 243
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/q_learning_table_agent_top.sv @@
// Q-learning table agent with epsilon-greedy choice: controller, arithmetic and table.
// Depends on qlta_pkg, qlta_cmd_if, qlta_res_if, qlta_rem, qlta_mem and assert_macros.svh.
// The Q table lives in one memory of MAX_POSITIONS*HISTORY_SLOTS rows, each row holding all
// actions, so one read fetches a whole row. After reset, and for every clear command, the
// block writes 2.0 to every row, one row per cycle; no item is accepted during the reset
// pass. Items are handled one at a time, and the next item can be taken in the cycle after
// a result has been loaded. A greedy choice breaks ties with a serial remainder and a scan
// over the row, and any result may wait for the output register. A finished result waits
// in that register while the next item is taken.
`include "assert_macros.svh"

module q_learning_table_agent_top import qlta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qlta_cmd_if.sink          i_cmd,
    qlta_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);
    localparam int ROWS     = MAX_POSITIONS * HISTORY_SLOTS;
    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int EW       = $clog2(ACTIONS);
    localparam int LW       = $clog2(ACTIONS + 1);
    localparam int ROW_BITS = ACTIONS * QW;
    localparam int PICK_SH  = 20;
    localparam int PICK_W   = PICK_SH + 1;
    localparam int PROD_W   = RND_W + PICK_W;
    localparam logic [PICK_W-1:0] PICK_M = PICK_W'((2 ** PICK_SH + ACTIONS - 1) / ACTIONS);

    localparam logic signed [33:0] NV_HI = 34'sd65470464;
    localparam logic signed [33:0] NV_LO = -34'sd65470464;

    typedef enum logic [17:0] {
        S_IDLE  = 18'b000000000000000001,
        S_INIT  = 18'b000000000000000010,
        S_ROW   = 18'b000000000000000100,
        S_RD_A  = 18'b000000000000001000,
        S_CAP_A = 18'b000000000000010000,
        S_MAX   = 18'b000000000000100000,
        S_EQ    = 18'b000000000001000000,
        S_PREM  = 18'b000000000010000000,
        S_SEL   = 18'b000000000100000000,
        S_RD_B  = 18'b000000001000000000,
        S_CAP_B = 18'b000000010000000000,
        S_M1    = 18'b000000100000000000,
        S_M2    = 18'b000001000000000000,
        S_M3    = 18'b000010000000000000,
        S_M4    = 18'b000100000000000000,
        S_M5    = 18'b001000000000000000,
        S_SWEEP = 18'b010000000000000000,
        S_OUT   = 18'b100000000000000000
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic signed [QW-1:0]  r_reward;
    logic [RND_W-1:0]      r_rexp;
    logic [RND_W-1:0]      r_rpick;
    logic [RW-1:0]         r_slot_row;
    logic [RW-1:0]         r_raw_row;
    logic [RW-1:0]         r_prev_row;
    logic [RW-1:0]         r_rd_addr;
    logic [RW-1:0]         r_sweep;
    logic [LW-1:0]         r_last;
    logic [CFG_W-1:0]      r_learn;
    logic [CFG_W-1:0]      r_disc;
    logic [CFG_W-1:0]      r_eps;
    logic [ES_W-1:0]       r_env;
    logic [ROW_BITS-1:0]   r_row;
    logic [EW-1:0]         r_idx;
    t_q                    r_max;
    t_q                    r_q;
    logic [ACTIONS-1:0]    r_mask;
    logic [LW-1:0]         r_seen;
    logic [LW-1:0]         r_target;
    logic                  r_explored;
    logic [LW-1:0]         r_action;
    t_status               r_status;
    logic signed [44:0]    r_p1;
    logic signed [29:0]    r_tgt;
    logic signed [30:0]    r_diff;
    logic signed [48:0]    r_p2;
    logic                  r_out_valid;
    logic [ACT_W-1:0]      r_o_action;
    t_q                    r_o_max;
    logic                  r_o_explored;
    t_status               r_o_status;

    logic                  w_accept;
    logic signed [5:0]     w_it_m1;
    logic signed [13:0]    w_s_slot;
    logic signed [13:0]    w_s_raw;
    logic [RW-1:0]         w_slot_row;
    logic [RW-1:0]         w_raw_row;
    logic                  w_pick_start;
    logic                  w_pick_done;
    logic [LW-1:0]         w_pick_rem;
    logic [PROD_W-1:0]     w_pick_prod;
    logic [RND_W-1:0]      w_pick_quo;
    logic [LW-1:0]         w_pick_mod;
    logic [ACTIONS-1:0]    w_mask;
    logic [LW-1:0]         w_cnt;
    t_q                    w_cur;
    logic                  w_last_idx;
    logic                  w_explore;
    logic [EW-1:0]         w_lidx;
    logic signed [44:0]    w_r1;
    logic signed [48:0]    w_r2;
    logic signed [33:0]    w_nv;
    t_q                    w_nv_sat;
    logic                  w_sat;
    logic [ROW_BITS-1:0]   w_new_row;
    logic                  w_we;
    logic [RW-1:0]         w_waddr;
    logic [ROW_BITS-1:0]   w_wdata;
    logic [ROW_BITS-1:0]   w_rdata;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_it_m1  = $signed({1'b0, i_cmd.iteration}) - 6'sd1;
    assign w_s_slot = $signed({7'b0, i_cmd.position}) + $signed({1'b0, r_env}) * w_it_m1
                      - 14'sd1;
    assign w_s_raw  = $signed({7'b0, i_cmd.position}) - 14'sd1;

    // The row count divides 2^14, so the wrapped row is the low bits of the signed sum.
    assign w_slot_row = w_s_slot[RW-1:0];
    assign w_raw_row  = w_s_raw[RW-1:0];

    always_comb begin
        for (int i = 0; i < ACTIONS; i++) begin
            w_mask[i] = ($signed(r_row[i*QW +: QW]) == r_max);
        end
    end

    assign w_cnt        = LW'($countones(w_mask));
    assign w_cur        = r_row[int'(r_idx)*QW +: QW];
    assign w_last_idx   = (r_idx == EW'(ACTIONS - 1));
    assign w_explore    = {1'b0, r_rexp} < clamp_one(r_eps);
    assign w_pick_start = (r_state == S_EQ);

    // Reciprocal multiplication gives the exact quotient by ACTIONS for every 16-bit value.
    assign w_pick_prod = {{PICK_W{1'b0}}, r_rpick} * {{RND_W{1'b0}}, PICK_M};
    assign w_pick_quo  = w_pick_prod[PICK_SH +: RND_W];
    assign w_pick_mod  = LW'(r_rpick - w_pick_quo * RND_W'(ACTIONS));

    qlta_rem #(.DW(RND_W), .VW(LW)) u_pick_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_pick_start),
        .i_dividend (r_rpick),
        .i_divisor  (w_cnt),
        .o_done     (w_pick_done),
        .o_rem      (w_pick_rem)
    );

    assign w_lidx   = EW'(r_last - LW'(1));
    assign w_r1     = (r_p1 + 45'sd32768) >>> 16;
    assign w_r2     = (r_p2 + 49'sd32768) >>> 16;
    assign w_nv     = w_r2[33:0] + {{7{r_q[QW-1]}}, r_q};
    assign w_sat    = (w_nv > NV_HI) || (w_nv < NV_LO);
    assign w_nv_sat = (w_nv > NV_HI) ? NV_HI[QW-1:0] :
                      (w_nv < NV_LO) ? NV_LO[QW-1:0] : w_nv[QW-1:0];

    always_comb begin
        w_new_row = r_row;
        w_new_row[int'(w_lidx)*QW +: QW] = w_nv_sat;
    end

    assign w_we    = (r_state == S_INIT) || (r_state == S_SWEEP) || (r_state == S_M5);
    assign w_waddr = (r_state == S_M5) ? r_prev_row : r_sweep;
    assign w_wdata = (r_state == S_M5) ? w_new_row : {ACTIONS{Q_INIT}};

    qlta_mem #(.DEPTH(ROWS), .AW(RW), .DW(ROW_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_prev_row  <= '0;
            r_last      <= '0;
            r_rd_addr   <= '0;
            r_learn     <= 17'd32768;
            r_disc      <= 17'd58982;
            r_eps       <= 17'd6554;
            r_env       <= 7'd64;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LEARN_RATE: r_learn <= i_cfg_data;
                    CFG_DISCOUNT:   r_disc  <= i_cfg_data;
                    CFG_EXPLORE:    r_eps   <= i_cfg_data;
                    CFG_ENV_STATES: r_env   <= i_cfg_data[ES_W-1:0];
                    default: ;
                endcase
            end

            if (o_res.valid && o_res.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_INIT: begin
                    if (r_sweep == RW'(ROWS - 1)) begin
                        r_sweep <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + RW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= i_cmd.command;
                        r_reward   <= i_cmd.reward;
                        r_rexp     <= i_cmd.rand_explore;
                        r_rpick    <= i_cmd.rand_pick;
                        r_slot_row <= w_slot_row;
                        r_raw_row  <= w_raw_row;
                        r_state    <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_action   <= '0;
                    r_explored <= 1'b0;
                    r_status   <= ST_OK;
                    r_max      <= '0;
                    case (r_cmd)
                        CMD_CHOOSE: begin
                            r_rd_addr <= r_slot_row;
                            r_state   <= S_RD_A;
                        end
                        CMD_LEARN: begin
                            r_rd_addr <= r_raw_row;
                            r_state   <= S_RD_A;
                        end
                        CMD_RECORD: begin
                            r_prev_row <= r_slot_row;
                            r_state    <= S_OUT;
                        end
                        CMD_CLEAR: begin
                            r_prev_row <= r_raw_row;
                            r_last     <= '0;
                            r_sweep    <= '0;
                            r_state    <= S_SWEEP;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_RD_A: r_state <= S_CAP_A;
                S_CAP_A: begin
                    r_row   <= w_rdata;
                    r_max   <= w_rdata[QW-1:0];
                    r_idx   <= EW'(1);
                    r_state <= S_MAX;
                end
                S_MAX: begin
                    if (w_cur > r_max) begin
                        r_max <= w_cur;
                    end
                    if (w_last_idx) begin
                        if (r_cmd == CMD_LEARN) begin
                            if (r_last == '0) begin
                                r_status <= ST_NO_ACTION;
                                r_state  <= S_OUT;
                            end else begin
                                r_rd_addr <= r_prev_row;
                                r_state   <= S_RD_B;
                            end
                        end else if (w_explore) begin
                            r_explored <= 1'b1;
                            r_action   <= w_pick_mod + LW'(1);
                            r_last     <= w_pick_mod + LW'(1);
                            r_state    <= S_OUT;
                        end else begin
                            r_state <= S_EQ;
                        end
                    end else begin
                        r_idx <= r_idx + EW'(1);
                    end
                end
                S_EQ: begin
                    r_mask  <= w_mask;
                    r_seen  <= '0;
                    r_idx   <= '0;
                    r_state <= S_PREM;
                end
                S_PREM: begin
                    if (w_pick_done) begin
                        r_target <= w_pick_rem;
                        r_state  <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_idx <= r_idx + EW'(1);
                    if (r_mask[r_idx]) begin
                        if (r_seen == r_target) begin
                            r_action <= LW'(r_idx) + LW'(1);
                            r_last   <= LW'(r_idx) + LW'(1);
                            r_state  <= S_OUT;
                        end else begin
                            r_seen <= r_seen + LW'(1);
                        end
                    end
                end
                S_RD_B: r_state <= S_CAP_B;
                S_CAP_B: begin
                    r_row   <= w_rdata;
                    r_q     <= w_rdata[int'(w_lidx)*QW +: QW];
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_p1    <= r_max * $signed({1'b0, clamp_one(r_disc)});
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_tgt   <= w_r1[29:0] + {{3{r_reward[QW-1]}}, r_reward};
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_diff  <= {r_tgt[29], r_tgt} - {{4{r_q[QW-1]}}, r_q};
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_p2    <= r_diff * $signed({1'b0, clamp_one(r_learn)});
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_status <= w_sat ? ST_SAT : ST_OK;
                    r_state  <= S_OUT;
                end
                S_SWEEP: begin
                    if (r_sweep == RW'(ROWS - 1)) begin
                        r_sweep <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_sweep <= r_sweep + RW'(1);
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_o_action   <= ACT_W'(r_action);
                        r_o_max      <= r_max;
                        r_o_explored <= r_explored;
                        r_o_status   <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.action    = r_o_action;
    assign o_res.max_value = r_o_max;
    assign o_res.explored  = r_o_explored;
    assign o_res.status    = r_o_status;

    `QLTA_ASSERT_NXT(a_accept_to_row, i_clk, i_rst_n, w_accept, r_state == S_ROW, "accepted item did not start row folding")
    `QLTA_ASSERT_IMP(a_learn_has_action, i_clk, i_rst_n, r_state == S_M5, r_last != '0, "table update without a chosen action")
    `QLTA_ASSERT_IMP(a_result_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT), "result loaded outside the output state")
    `QLTA_ASSERT_IMP(a_pick_done_waited, i_clk, i_rst_n, w_pick_done, r_state == S_PREM, "pick remainder finished while not awaited")
endmodule
